FILE: hdl/tcham_pkg.sv
package tcham_pkg;

  localparam int CmdW    = 2;
  localparam int SampleW = 12;
  localparam int ValueW  = 11;
  localparam int LedW    = 7;
  localparam int RedW    = 6;
  localparam int PreW    = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_POT  = 2'd0,
    CMD_INT  = 2'd1,
    CMD_EXT  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POT_THR = 3'd0,
    REG_POT_HYS = 3'd1,
    REG_INT_THR = 3'd2,
    REG_INT_HYS = 3'd3,
    REG_EXT_THR = 3'd4,
    REG_EXT_HYS = 3'd5
  } reg_idx_t;

  localparam logic [PreW-1:0] PRE_IDLE  = 15'd100;
  localparam logic [PreW-1:0] PRE_ONE   = 15'd20000;
  localparam logic [PreW-1:0] PRE_TWO   = 15'd8000;
  localparam logic [PreW-1:0] PRE_THREE = 15'd4000;
  localparam logic [RedW-1:0] RED_BLINK = 6'd50;

endpackage

FILE: hdl/three_channel_hysteresis_alarm_monitor.sv
// path from input beat to result beat: input register, then result register
// one beat per cycle while out_ready does not stall the output; the scaling and alarm update is a single
// combinational pass between the two registers
// a sample on channel code three is dropped and yields no result beat
// reset (rst, synchronous): flags and LED levels cleared, prescaler 100, registers to defaults
module three_channel_hysteresis_alarm_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcham_pkg::CmdW-1:0]    cmd,
  input  logic [tcham_pkg::SampleW-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcham_pkg::ValueW-1:0]  scaled_value,
  output logic [tcham_pkg::LedW-1:0]    green_duty,
  output logic [tcham_pkg::ValueW-1:0]  orange_duty,
  output logic [tcham_pkg::LedW-1:0]    blue_duty,
  output logic [tcham_pkg::RedW-1:0]    red_duty,
  output logic [tcham_pkg::PreW-1:0]    blink_prescale,
  output logic                          alarm_pot,
  output logic                          alarm_int,
  output logic                          alarm_ext,
  output logic [1:0]                    alarm_count,
  input  logic                          cfg_write,
  input  logic [tcham_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tcham_pkg::CfgW-1:0]    cfg_data
);
  import tcham_pkg::*;

  logic [6:0]         pot_thr, pot_hys, ext_thr, ext_hys;
  logic [ValueW-1:0]  int_thr, int_hys;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_thr <= 7'd90;
      pot_hys <= 7'd10;
      int_thr <= 11'd65;
      int_hys <= 11'd5;
      ext_thr <= 7'd45;
      ext_hys <= 7'd5;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POT_THR: pot_thr <= cfg_data[6:0];
        REG_POT_HYS: pot_hys <= cfg_data[6:0];
        REG_INT_THR: int_thr <= cfg_data;
        REG_INT_HYS: int_hys <= cfg_data;
        REG_EXT_THR: ext_thr <= cfg_data[6:0];
        REG_EXT_HYS: ext_hys <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid;
  cmd_t               s1_cmd;
  logic [SampleW-1:0] s1_sample;
  logic               advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd    <= cmd_t'(cmd);
      s1_sample <= sample;
    end
  end

  // potentiometer: s*99/4095 + 1
  logic [18:0] pot_prod;
  logic [6:0]  pot_q0;
  logic [12:0] pot_rem;
  logic [6:0]  pot_q;
  logic [ValueW-1:0] pot_v;

  assign pot_prod = 19'(s1_sample) * 19'd99;
  assign pot_q0   = pot_prod[18:12];
  assign pot_rem  = {1'b0, pot_prod[11:0]} + 13'(pot_q0);
  assign pot_q    = pot_q0 + 7'(pot_rem >= 13'd4095);
  assign pot_v    = 11'(pot_q) + 11'd1;

  // internal temperature: s*1320/4096 - 279, floor 0
  logic [22:0]       int_prod;
  logic [ValueW-1:0] int_t, int_v;

  assign int_prod = 23'(s1_sample) * 23'd1320;
  assign int_t    = int_prod[22:12];
  assign int_v    = (int_t > 11'd279) ? int_t - 11'd279 : '0;

  // external temperature: u = s*330/4096, d = (u-2)*99/200 by reciprocal
  logic [20:0]       ext_prod;
  logic [8:0]        ext_u, ext_w;
  logic [25:0]       ext_m;
  logic [7:0]        ext_d;
  logic [ValueW-1:0] ext_v;

  assign ext_prod = 21'(s1_sample) * 21'd330;
  assign ext_u    = ext_prod[20:12];
  assign ext_w    = ext_u - 9'd2;
  assign ext_m    = 26'(ext_w) * 26'd129762;
  assign ext_d    = ext_m[25:18];
  always_comb begin
    if (ext_u <= 9'd2) ext_v = 11'd100;
    else if (ext_d >= 8'd100) ext_v = '0;
    else ext_v = 11'd100 - 11'(ext_d);
  end

  // alarm update
  logic [ValueW-1:0] v, thr, hys;
  logic              flag, flag_next;
  logic [11:0]       v_plus_hys;

  always_comb begin
    case (s1_cmd)
      CMD_POT: begin
        v = pot_v; thr = 11'(pot_thr); hys = 11'(pot_hys); flag = alarm_pot;
      end
      CMD_INT: begin
        v = int_v; thr = int_thr; hys = int_hys; flag = alarm_int;
      end
      default: begin
        v = ext_v; thr = 11'(ext_thr); hys = 11'(ext_hys); flag = alarm_ext;
      end
    endcase
  end

  assign v_plus_hys = 12'(v) + 12'(hys);
  always_comb begin
    if (v > thr) flag_next = 1'b1;
    else if (v_plus_hys < 12'(thr)) flag_next = 1'b0;
    else flag_next = flag;
  end

  logic        pot_next, int_next, ext_next;
  logic [1:0]  count_next;
  logic [ValueW-1:0] duty;
  logic        take;

  assign pot_next   = (s1_cmd == CMD_POT) ? flag_next : alarm_pot;
  assign int_next   = (s1_cmd == CMD_INT) ? flag_next : alarm_int;
  assign ext_next   = (s1_cmd == CMD_EXT) ? flag_next : alarm_ext;
  assign count_next = 2'(pot_next) + 2'(int_next) + 2'(ext_next);
  assign duty       = (v != '0) ? v - 11'd1 : '0;
  assign take       = advance && s1_valid && (s1_cmd != CMD_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_pot      <= 1'b0;
      alarm_int      <= 1'b0;
      alarm_ext      <= 1'b0;
      alarm_count    <= '0;
      green_duty     <= '0;
      orange_duty    <= '0;
      blue_duty      <= '0;
      red_duty       <= '0;
      blink_prescale <= PRE_IDLE;
      scaled_value   <= '0;
    end else if (take) begin
      alarm_pot    <= pot_next;
      alarm_int    <= int_next;
      alarm_ext    <= ext_next;
      alarm_count  <= count_next;
      scaled_value <= v;
      if (count_next == 2'd0) begin
        red_duty       <= '0;
        blink_prescale <= PRE_IDLE;
        case (s1_cmd)
          CMD_POT: blue_duty   <= duty[6:0];
          CMD_INT: orange_duty <= duty;
          default: green_duty  <= duty[6:0];
        endcase
      end else begin
        green_duty  <= '0;
        orange_duty <= '0;
        blue_duty   <= '0;
        red_duty    <= RED_BLINK;
        case (count_next)
          2'd1:    blink_prescale <= PRE_ONE;
          2'd2:    blink_prescale <= PRE_TWO;
          default: blink_prescale <= PRE_THREE;
        endcase
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alarm_count == 2'(alarm_pot) + 2'(alarm_int) + 2'(alarm_ext))
    else $error("alarm count does not match flags");

  a_red_follows_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((red_duty != '0) == (alarm_count != 2'd0)))
    else $error("alarm LED out of step with alarm count");

  a_idle_prescale: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_count == 2'd0 |-> blink_prescale == PRE_IDLE)
    else $error("prescaler not idle with no alarm");

  a_dark_on_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_count != 2'd0 |->
      green_duty == '0 && orange_duty == '0 && blue_duty == '0)
    else $error("channel LED lit during alarm");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcham_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 55;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LedW-1:0]   green;
    logic [ValueW-1:0] orange;
    logic [LedW-1:0]   blue;
    logic [RedW-1:0]   red;
    logic [PreW-1:0]   prescale;
    logic              a_pot;
    logic              a_int;
    logic              a_ext;
    logic [1:0]        count;
  } readout_t;

  typedef struct {
    cmd_t               ch;
    logic [SampleW-1:0] s;
    bit                 typed;
    readout_t           want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cmd_t               cmd = CMD_POT;
  logic [SampleW-1:0] sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ValueW-1:0]  scaled_value;
  logic [LedW-1:0]    green_duty;
  logic [ValueW-1:0]  orange_duty;
  logic [LedW-1:0]    blue_duty;
  logic [RedW-1:0]    red_duty;
  logic [PreW-1:0]    blink_prescale;
  logic               alarm_pot;
  logic               alarm_int;
  logic               alarm_ext;
  logic [1:0]         alarm_count;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  three_channel_hysteresis_alarm_monitor DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .scaled_value(scaled_value), .green_duty(green_duty), .orange_duty(orange_duty),
    .blue_duty(blue_duty), .red_duty(red_duty), .blink_prescale(blink_prescale),
    .alarm_pot(alarm_pot), .alarm_int(alarm_int), .alarm_ext(alarm_ext),
    .alarm_count(alarm_count),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitor settings and state
  logic [LedW-1:0]   pot_thr, pot_hys, ext_thr, ext_hys;
  logic [ValueW-1:0] int_thr, int_hys;
  bit                pot_on, int_on, ext_on;
  logic [LedW-1:0]   green_lv, blue_lv;
  logic [ValueW-1:0] orange_lv;
  logic [RedW-1:0]   red_lv;
  logic [PreW-1:0]   pre_lv;

  readout_t readout_q[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       hold_req = 1'b0;
  stim_row_t dir_rows [25];

  task automatic reset_monitor();
    pot_thr = 7'd90;  pot_hys = 7'd10;
    int_thr = 11'd65; int_hys = 11'd5;
    ext_thr = 7'd45;  ext_hys = 7'd5;
    pot_on = 1'b0; int_on = 1'b0; ext_on = 1'b0;
    green_lv = '0; orange_lv = '0; blue_lv = '0; red_lv = '0;
    pre_lv = PRE_IDLE;
  endtask

  function automatic int unsigned scale_sample(input cmd_t c, input logic [SampleW-1:0] s);
    int unsigned x, t, u, d;
    x = s;
    case (c)
      CMD_POT: return x * 99 / 4095 + 1;
      CMD_INT: begin
        t = x * 1320 / 4096;
        return (t > 279) ? t - 279 : 0;
      end
      default: begin
        u = x * 330 / 4096;
        if (u <= 2) return 100;
        d = (u - 2) * 99 / 200;
        return (d >= 100) ? 0 : 100 - d;
      end
    endcase
  endfunction

  function automatic bit hyst_next(input bit cur, input int unsigned v,
                                   input int unsigned thr, input int unsigned hys);
    if (v > thr) return 1'b1;
    if (v + hys < thr) return 1'b0;
    return cur;
  endfunction

  function automatic bit predict_readout(input cmd_t c, input logic [SampleW-1:0] s,
                                         output readout_t r);
    int unsigned v, duty, n;
    r = '0;
    if (c == CMD_NONE) return 1'b0;
    v = scale_sample(c, s);
    case (c)
      CMD_POT: pot_on = hyst_next(pot_on, v, pot_thr, pot_hys);
      CMD_INT: int_on = hyst_next(int_on, v, int_thr, int_hys);
      default: ext_on = hyst_next(ext_on, v, ext_thr, ext_hys);
    endcase
    n = pot_on + int_on + ext_on;
    if (n == 0) begin
      duty = (v > 0) ? v - 1 : 0;
      red_lv = '0;
      pre_lv = PRE_IDLE;
      case (c)
        CMD_POT: blue_lv = LedW'(duty);
        CMD_INT: orange_lv = ValueW'(duty);
        default: green_lv = LedW'(duty);
      endcase
    end else begin
      green_lv = '0; orange_lv = '0; blue_lv = '0;
      red_lv = RED_BLINK;
      pre_lv = (n == 1) ? PRE_ONE : (n == 2) ? PRE_TWO : PRE_THREE;
    end
    r.value = ValueW'(v);
    r.green = green_lv;
    r.orange = orange_lv;
    r.blue = blue_lv;
    r.red = red_lv;
    r.prescale = pre_lv;
    r.a_pot = pot_on;
    r.a_int = int_on;
    r.a_ext = ext_on;
    r.count = 2'(n);
    return 1'b1;
  endfunction

  // of every 100 samples, 45 aim at values near the alarm window of the channel, 10 are extremes, the rest random
  function automatic logic [SampleW-1:0] pick_sample(input cmd_t c);
    int unsigned thr, hys, v, roll;
    logic [SampleW-1:0] s;
    roll = $urandom_range(99);
    s = SampleW'($urandom_range(4095));
    if (roll < 10) begin
      s = $urandom_range(1) ? '1 : '0;
    end else if (roll < 55) begin
      case (c)
        CMD_POT: begin thr = pot_thr; hys = pot_hys; end
        CMD_INT: begin thr = int_thr; hys = int_hys; end
        default: begin thr = ext_thr; hys = ext_hys; end
      endcase
      for (int k = 0; k < 64; k++) begin
        v = scale_sample(c, s);
        if (v <= thr + 1 && v + hys + 1 >= thr) break;
        s = SampleW'($urandom_range(4095));
      end
    end
    return s;
  endfunction

  task automatic note_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      $display("mismatch %s: got %0d want %0d", name, got, want);
      mismatches++;
    end
  endtask

  task automatic offer_sample(input cmd_t c, input logic [SampleW-1:0] s,
                              input bit typed, input readout_t want);
    readout_t pred;
    bit produced;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    sample <= s;
    do @(posedge clk); while (!in_ready);
    produced = predict_readout(c, s, pred);
    if (produced) readout_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readout_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_POT_THR: pot_thr = data[LedW-1:0];
      REG_POT_HYS: pot_hys = data[LedW-1:0];
      REG_INT_THR: int_thr = data;
      REG_INT_HYS: int_hys = data;
      REG_EXT_THR: ext_thr = data[LedW-1:0];
      REG_EXT_HYS: ext_hys = data[LedW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [CfgW-1:0] pt, input logic [CfgW-1:0] ph,
                           input logic [CfgW-1:0] it, input logic [CfgW-1:0] ih,
                           input logic [CfgW-1:0] et, input logic [CfgW-1:0] eh);
    write_reg(REG_POT_THR, pt);
    write_reg(REG_POT_HYS, ph);
    write_reg(REG_INT_THR, it);
    write_reg(REG_INT_HYS, ih);
    write_reg(REG_EXT_THR, et);
    write_reg(REG_EXT_HYS, eh);
    cfg_write <= 1'b0;
  endtask

  // receiver side, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    readout_t want;
    if (!rst && out_valid && out_ready) begin
      if (readout_q.size() == 0) begin
        note_field("beat without prediction", 1, 0);
      end else begin
        want = readout_q.pop_front();
        note_field("scaled_value", scaled_value, want.value);
        note_field("green_duty", green_duty, want.green);
        note_field("orange_duty", orange_duty, want.orange);
        note_field("blue_duty", blue_duty, want.blue);
        note_field("red_duty", red_duty, want.red);
        note_field("blink_prescale", blink_prescale, want.prescale);
        note_field("alarm_pot", alarm_pot, want.a_pot);
        note_field("alarm_int", alarm_int, want.a_int);
        note_field("alarm_ext", alarm_ext, want.a_ext);
        note_field("alarm_count", alarm_count, want.count);
      end
    end
  end

  initial begin
    cmd_t c;
    int sent;
    dir_rows = '{
      '{CMD_POT, 12'd0, 1'b1,
        '{11'd1, 7'd0, 11'd0, 7'd0, 6'd0, PRE_IDLE, 1'b0, 1'b0, 1'b0, 2'd0}},
      '{CMD_POT, 12'd4095, 1'b1,
        '{11'd100, 7'd0, 11'd0, 7'd0, RED_BLINK, PRE_ONE, 1'b1, 1'b0, 1'b0, 2'd1}},
      '{CMD_POT, 12'd0, 1'b1,
        '{11'd1, 7'd0, 11'd0, 7'd0, 6'd0, PRE_IDLE, 1'b0, 1'b0, 1'b0, 2'd0}},
      '{CMD_INT, 12'd0, 1'b1,
        '{11'd0, 7'd0, 11'd0, 7'd0, 6'd0, PRE_IDLE, 1'b0, 1'b0, 1'b0, 2'd0}},
      '{CMD_INT, 12'd4095, 1'b1,
        '{11'd1040, 7'd0, 11'd0, 7'd0, RED_BLINK, PRE_ONE, 1'b0, 1'b1, 1'b0, 2'd1}},
      '{CMD_EXT, 12'd0, 1'b1,
        '{11'd100, 7'd0, 11'd0, 7'd0, RED_BLINK, PRE_TWO, 1'b0, 1'b1, 1'b1, 2'd2}},
      '{CMD_POT, 12'd4095, 1'b1,
        '{11'd100, 7'd0, 11'd0, 7'd0, RED_BLINK, PRE_THREE, 1'b1, 1'b1, 1'b1, 2'd3}},
      '{CMD_NONE, 12'd4095, 1'b0, '0},
      '{CMD_EXT, 12'd4095, 1'b1,
        '{11'd0, 7'd0, 11'd0, 7'd0, RED_BLINK, PRE_TWO, 1'b1, 1'b1, 1'b0, 2'd2}},
      '{CMD_INT, 12'd0, 1'b0, '0},
      '{CMD_POT, 12'd0, 1'b0, '0},
      '{CMD_INT, 12'd868, 1'b0, '0},
      '{CMD_INT, 12'd869, 1'b0, '0},
      '{CMD_EXT, 12'd37, 1'b0, '0},
      '{CMD_EXT, 12'd38, 1'b0, '0},
      '{CMD_EXT, 12'd2533, 1'b0, '0},
      '{CMD_EXT, 12'd2545, 1'b0, '0},
      '{CMD_POT, 12'd3700, 1'b0, '0},
      '{CMD_POT, 12'd3750, 1'b0, '0},
      '{CMD_POT, 12'd3400, 1'b0, '0},
      '{CMD_POT, 12'd3200, 1'b0, '0},
      '{CMD_NONE, 12'd0, 1'b0, '0},
      '{CMD_INT, 12'd1500, 1'b0, '0},
      '{CMD_EXT, 12'd1000, 1'b0, '0},
      '{CMD_POT, 12'd2048, 1'b0, '0}
    };
    reset_monitor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 73;
    foreach (dir_rows[i]) offer_sample(dir_rows[i].ch, dir_rows[i].s, dir_rows[i].typed,
                                       dir_rows[i].want);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 16; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        1: load_regs('0, '0, '0, '0, '0, '0);
        3: load_regs('1, '1, '1, '1, '1, '1);
        5: load_regs(11'd100, 11'd100, 11'd1040, 11'd1040, 11'd100, 11'd100);
        8: begin
          write_reg(REG_UNUSED, '1);
          load_regs(11'd90, 11'd10, 11'd65, 11'd5, 11'd45, 11'd5);
        end
        default: load_regs(CfgW'($urandom_range(100)), CfgW'($urandom_range(25)),
                           CfgW'($urandom_range(1040)), CfgW'($urandom_range(260)),
                           CfgW'($urandom_range(100)), CfgW'($urandom_range(25)));
      endcase
      if (p == 6) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(99) < 5) begin
          offer_sample(CMD_NONE, SampleW'($urandom_range(4095)), 1'b0, '0);
        end else begin
          c = cmd_t'($urandom_range(2));
          offer_sample(c, pick_sample(c), 1'b0, '0);
          sent++;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
